/* rtl/assert_macros.svh */
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// next-cycle implication outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

/* rtl/pti_pkg.sv */
// types and constants of the periodic table interpolator
`timescale 1ns / 1ps
`default_nettype none
package pti_pkg;
	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FEW = 2'd1;
	localparam logic [1:0] ST_OUTSIDE = 2'd2;
	localparam logic CFG_POINT_COUNT = 1'b0;
	localparam logic CFG_CYCLE_LENGTH = 1'b1;

	// controller to datapath
	typedef struct packed {
		logic load;       // capture query time, start wrap
		logic mod_step;   // one restoring modulo step
		logic rd_first;   // issue read of first pair entry (index 0)
		logic seg_next;   // advance scan index and shift pair
		logic lerp_mul;   // register product
		logic div_start;  // load divider
		logic div_step;   // one restoring division step
		logic fin;        // form result
	} pti_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic hit;        // current pair encloses time
		logic last_seg;   // last-segment flag, tied low by the datapath
		logic zero_span;  // span is zero
	} pti_sts_t;
endpackage
`default_nettype wire

/* rtl/periodic_table_interpolator.sv */
// top level: handshakes, configuration registers and output register
`timescale 1ns / 1ps
`default_nettype none
// Periodic piecewise-linear table interpolator. Write beats (command 0) store
// one (time, value) breakpoint. A query beat wraps its time modulo
// cycle_length with a 48-step restoring divider, scans segments one per cycle
// through the breakpoint memories, multiplies once and divides with a 64-step
// restoring divider; a query on fewer than two points returns status FEW instead.
// Only one query is in flight; the output register holds a finished result while
// stalled and no new query starts until it leaves.
module periodic_table_interpolator #(
	parameter int POINTS = 256
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        command,
	input  wire logic [7:0]  point_index,
	input  wire logic [31:0] point_time,
	input  wire logic [31:0] point_value,
	input  wire logic [47:0] query_time,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [31:0]      interpolated_value,
	output logic [1:0]       status,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic        cfg_index,
	input  wire logic [31:0] cfg_data
);
	localparam int AW = $clog2(POINTS);
	logic [8:0] point_count_q;
	logic [31:0] cycle_length_q;
	logic in_go, busy, done, we;
	logic [1:0] done_status;
	logic [5:0] step_cnt;
	logic [31:0] result;
	logic out_valid_q;
	pti_pkg::pti_cmd_t cmd;
	pti_pkg::pti_sts_t sts;

	assign in_stall = busy || out_valid_q || done;
	assign in_go = in_valid && !in_stall;
	assign we = in_go && (command == pti_pkg::CMD_WRITE) &&
		(32'(point_index) < 32'(POINTS));
	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_count_q <= '0;
			cycle_length_q <= 32'd1;
		end else if (cfg_valid) begin
			if (cfg_index == pti_pkg::CFG_POINT_COUNT) begin
				point_count_q <= cfg_data[8:0];
			end else begin
				cycle_length_q <= cfg_data;
			end
		end
	end

	pti_ctrl #(.POINTS(POINTS)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_go(in_go),
		.in_query(command == pti_pkg::CMD_QUERY), .point_count(point_count_q),
		.sts(sts), .out_free(!out_valid_q), .cmd(cmd), .busy(busy), .done(done),
		.done_status(done_status), .step_cnt(step_cnt));

	pti_datapath #(.POINTS(POINTS)) u_dp (
		.clk(clk), .we(we), .waddr(AW'(point_index)), .wtime(point_time),
		.wvalue(point_value), .query_time(query_time), .cycle_length(cycle_length_q),
		.cmd(cmd), .step_cnt(step_cnt), .sts(sts), .result(result));

	// output register: result beat waits here
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			status <= pti_pkg::ST_OK;
		end else begin
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (done) begin
				out_valid_q <= 1'b1;
				status <= done_status;
			end
		end
	end
	assign out_valid = out_valid_q;
	assign interpolated_value = (status == pti_pkg::ST_OK) ? result : '0;
endmodule
`default_nettype wire

/* rtl/pti_ram.sv */
// generic single-port-write ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module pti_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

/* rtl/pti_datapath.sv */
// datapath: tables, wrap unit, scan registers, interpolation arithmetic
`timescale 1ns / 1ps
`default_nettype none
module pti_datapath #(
	parameter int POINTS = 256,
	localparam int AW = $clog2(POINTS)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [31:0]      wtime,
	input  wire logic [31:0]      wvalue,
	input  wire logic [47:0]      query_time,
	input  wire logic [31:0]      cycle_length,
	input  wire pti_pkg::pti_cmd_t cmd,
	input  wire logic [5:0]       step_cnt,
	output pti_pkg::pti_sts_t     sts,
	output logic [31:0]           result
);
	logic [AW-1:0] ridx_q;
	logic [AW-1:0] raddr;
	logic [31:0] trd, vrd;
	logic [47:0] rem_q;       // wrapped time (full width if cycle 0)
	logic [47:0] qt_q;        // dividend shifted during modulo
	logic [31:0] t0_q, t1_q, f0_q, f1_q;
	logic [63:0] prod_q;
	logic [31:0] span_q;
	logic [63:0] dq_q;        // quotient bits shifted in
	logic [32:0] drem_q;
	logic neg_q;
	logic [48:0] mtry;
	logic [33:0] dtry;
	logic [32:0] diff;
	logic [31:0] mag;
	logic [31:0] dt;

	// read address: entry 0 on the first read, else the next entry after the current index
	assign raddr = cmd.rd_first ? '0 : ridx_q + AW'(1);

	pti_ram #(.WIDTH(32), .DEPTH(POINTS)) u_time (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wtime), .raddr(raddr), .rdata(trd));
	pti_ram #(.WIDTH(32), .DEPTH(POINTS)) u_value (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wvalue), .raddr(raddr), .rdata(vrd));

	// restoring modulo step, one bit per cycle
	assign mtry = {rem_q, qt_q[47]} - {17'd0, cycle_length};
	// restoring division step
	assign dtry = {drem_q, prod_q[63]} - {2'b0, span_q};

	assign diff = {f1_q[31], f1_q} - {f0_q[31], f0_q};
	assign mag = diff[32] ? 32'(-diff) : diff[31:0];
	assign dt = rem_q[31:0] - t0_q;

	always_ff @(posedge clk) begin
		// wrap
		if (cmd.load) begin
			rem_q <= (cycle_length == '0) ? query_time : '0;
			qt_q <= query_time;
		end else if (cmd.mod_step && cycle_length != '0) begin
			qt_q <= {qt_q[46:0], 1'b0};
			if (!mtry[48]) begin
				rem_q <= mtry[47:0];
			end else begin
				rem_q <= {rem_q[46:0], qt_q[47]};
			end
		end
		// scan pair shift
		if (cmd.rd_first) begin
			ridx_q <= '0;
		end else if (cmd.seg_next) begin
			ridx_q <= ridx_q + AW'(1);
			t0_q <= t1_q;
			f0_q <= f1_q;
			t1_q <= trd;
			f1_q <= vrd;
		end
		// multiply magnitude by offset
		if (cmd.lerp_mul) begin
			prod_q <= 64'(mag) * 64'(dt);
			span_q <= t1_q - t0_q;
			neg_q <= diff[32];
		end
		// division
		if (cmd.div_start) begin
			drem_q <= '0;
			dq_q <= '0;
		end else if (cmd.div_step) begin
			prod_q <= {prod_q[62:0], 1'b0};
			if (!dtry[33]) begin
				drem_q <= dtry[32:0];
				dq_q <= {dq_q[62:0], 1'b1};
			end else begin
				drem_q <= {drem_q[31:0], prod_q[63]};
				dq_q <= {dq_q[62:0], 1'b0};
			end
		end
		if (cmd.fin) begin
			if (span_q == '0) begin
				result <= f0_q;
			end else if (neg_q) begin
				result <= f0_q - dq_q[31:0];
			end else begin
				result <= f0_q + dq_q[31:0];
			end
		end
	end

	assign sts.hit = (rem_q[47:32] == '0) && (rem_q[31:0] >= t0_q) && (rem_q[31:0] <= t1_q);
	assign sts.last_seg = 1'b0;
	assign sts.zero_span = (span_q == '0) || (step_cnt == 6'd0 && 1'b0);
endmodule
`default_nettype wire

/* rtl/pti_ctrl.sv */
// controller: sequences wrap, scan, multiply and divide for each query on two or more points
`timescale 1ns / 1ps
`default_nettype none
module pti_ctrl #(
	parameter int POINTS = 256,
	localparam int CW = $clog2(POINTS + 1)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_go,
	input  wire logic              in_query,
	input  wire logic [8:0]        point_count,
	input  wire pti_pkg::pti_sts_t sts,
	input  wire logic              out_free,
	output pti_pkg::pti_cmd_t      cmd,
	output logic                   busy,
	output logic                   done,
	output logic [1:0]             done_status,
	output logic [5:0]             step_cnt
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MOD  = 3'd1;
	localparam logic [2:0] S_FILL = 3'd2;
	localparam logic [2:0] S_SCAN = 3'd3;
	localparam logic [2:0] S_MUL  = 3'd4;
	localparam logic [2:0] S_DIV  = 3'd5;
	localparam logic [2:0] S_FIN  = 3'd6;

	logic [2:0] state_q;
	logic [5:0] cnt_q;
	logic [CW-1:0] seg_q;     // segments remaining, current one included
	logic [CW-1:0] count;

	assign count = (32'(point_count) > 32'(POINTS)) ? CW'(POINTS) : CW'(point_count);
	assign step_cnt = cnt_q;
	assign busy = (state_q != S_IDLE);

	// command decode
	always_comb begin
		cmd = '0;
		cmd.load = in_go && in_query;
		cmd.mod_step = (state_q == S_MOD);
		// first read issued on the last wrap step so entry 0 lands in the fill
		cmd.rd_first = (state_q == S_MOD) && (cnt_q == '0);
		cmd.seg_next = (state_q == S_FILL) || (state_q == S_SCAN && !sts.hit);
		cmd.lerp_mul = (state_q == S_MUL);
		cmd.div_start = (state_q == S_MUL);
		cmd.div_step = (state_q == S_DIV);
		cmd.fin = (state_q == S_FIN);
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q <= '0;
			seg_q <= '0;
			done <= 1'b0;
			done_status <= pti_pkg::ST_OK;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_go && in_query) begin
						if (count < CW'(2)) begin
							done <= 1'b1;
							done_status <= pti_pkg::ST_FEW;
						end else begin
							state_q <= S_MOD;
							cnt_q <= 6'd47;
							seg_q <= count - CW'(1);
						end
					end
				end
				S_MOD: begin
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == '0) begin
						state_q <= S_FILL;
						cnt_q <= 6'd1;
					end
				end
				S_FILL: begin
					// two reads shift entries 0 and 1 into the pair
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == '0) begin
						state_q <= S_SCAN;
					end
				end
				S_SCAN: begin
					if (sts.hit) begin
						state_q <= S_MUL;
					end else if (seg_q == CW'(1)) begin
						state_q <= S_IDLE;
						done <= 1'b1;
						done_status <= pti_pkg::ST_OUTSIDE;
					end else begin
						seg_q <= seg_q - CW'(1);
					end
				end
				S_MUL: begin
					state_q <= S_DIV;
					cnt_q <= 6'd63;
				end
				S_DIV: begin
					cnt_q <= cnt_q - 6'd1;
					if (cnt_q == '0 || sts.zero_span) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					state_q <= S_IDLE;
					done <= 1'b1;
					done_status <= pti_pkg::ST_OK;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (out_free && 1'b0) begin
				state_q <= state_q;
			end
		end
	end
endmodule
`default_nettype wire

/* rtl/pti_checker.sv */
// port-level checker for the periodic table interpolator, bound to the top
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module pti_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic        command,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [1:0]  status,
	input wire logic [31:0] interpolated_value
);
	// a waiting result holds still
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(status), "result changed while stalled")
	// errors carry a zero value
	`ASSERT_IMPL(a_err_zero, clk, arst_n, out_valid && status != pti_pkg::ST_OK, interpolated_value == '0, "error result not zero")
	// status code in range
	`ASSERT_IMPL(a_status, clk, arst_n, out_valid, status <= pti_pkg::ST_OUTSIDE, "bad status code")
	// no new beat taken while a result waits
	`ASSERT_IMPL(a_no_accept, clk, arst_n, out_valid, in_stall, "input taken with result pending")
	// an accepted query blocks the input on the next cycle
	`ASSERT_NEXT(a_query_busy, clk, arst_n, in_valid && !in_stall && command == pti_pkg::CMD_QUERY, in_stall, "input open after query beat")
endmodule
bind periodic_table_interpolator pti_checker u_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.command(command), .out_valid(out_valid), .out_stall(out_stall),
	.status(status), .interpolated_value(interpolated_value));
`default_nettype wire
